// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, muted while reset is high
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also runs through reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/pfla_pkg.sv =====
// ----------------------------------------------------------------------------
// pfla_pkg
// Types and constants of the paged free-list allocator.
// ----------------------------------------------------------------------------
package pfla_pkg;

   localparam int HANDLE_W       = 8;
   localparam int LINK_W         = HANDLE_W + 1;
   localparam int LINK_DEPTH     = 1 << HANDLE_W;
   localparam int PAGES_W        = 4;
   localparam int PAGE_SLOTS_DEF = 32;
   localparam int MAX_PAGES_DEF  = 8;

   localparam logic [PAGES_W-1:0] PAGE_LIMIT_RST = 4'd8;

   typedef enum logic {
      FUNC_BORROW = 1'b0,
      FUNC_RETURN = 1'b1
   } func_type;

   // bit 8 valid, bits 7..0 handle
   typedef struct packed {
      logic                valid;
      logic [HANDLE_W-1:0] handle;
   } link_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_RET,
      ST_PROV,
      ST_PEND
   } state_type;

endpackage

// ===== rtl/pfla_if.sv =====
// ----------------------------------------------------------------------------
// pfla_req_if / pfla_rsp_if
// Valid/ready channels for allocator requests and responses.
// ----------------------------------------------------------------------------
interface pfla_req_if import pfla_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                func;
   logic [HANDLE_W-1:0] handle;
   logic                handle_present;

   modport source (output valid, func, handle, handle_present, input ready);
   modport sink   (input valid, func, handle, handle_present, output ready);
endinterface

interface pfla_rsp_if import pfla_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                granted;
   logic [HANDLE_W-1:0] granted_handle;
   logic [PAGES_W-1:0]  pages_used;

   modport source (output valid, granted, granted_handle, pages_used, input ready);
   modport sink   (input valid, granted, granted_handle, pages_used, output ready);
endinterface

// ===== rtl/pfla_ram.sv =====
// ----------------------------------------------------------------------------
// pfla_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pfla_ram #(
   parameter int WIDTH  = 9,
   parameter int DEPTH  = 256,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/paged_free_list_allocator.sv =====
// ----------------------------------------------------------------------------
// paged_free_list_allocator
// Free list of 8-bit buffer handles kept as links in a 256-entry memory.
// ----------------------------------------------------------------------------
// One request word at a time. A borrow served from the list waits in ST_READ
// for the link memory's registered read, and a return makes the second link
// write in ST_RET, before the response is loaded. A borrow that finds the
// list empty provisions a page by writing its slot links one per cycle
// through the single write port, or fails if no page can be provisioned.
// The next request word is accepted the cycle after the response is loaded
// into the output register, and a stalled response holds the block in its
// last step. The link memory needs no clearing after reset.
module paged_free_list_allocator import pfla_pkg::*; #(
   parameter int PAGE_SLOTS = PAGE_SLOTS_DEF,
   parameter int MAX_PAGES  = MAX_PAGES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   pfla_req_if.sink           req_ch,
   pfla_rsp_if.source         rsp_ch,
   input  logic               csr_we,
   input  logic [PAGES_W-1:0] csr_wdata
);

   `include "assert_macros.svh"

   localparam int SLOT_W = (PAGE_SLOTS > 1) ? $clog2(PAGE_SLOTS) : 1;
   localparam logic [SLOT_W-1:0]   SLOT_LAST = SLOT_W'(PAGE_SLOTS - 1);
   localparam logic [HANDLE_W-1:0] PAGE_STEP = HANDLE_W'(PAGE_SLOTS);

   state_type state_ff, state_in;
   link_type  head_ff, head_in;
   link_type  tail_ff, tail_in;
   link_type  tail_prov;
   logic [PAGES_W-1:0]  pages_ff, pages_in;
   logic [PAGES_W-1:0]  limit_ff, limit_in;
   logic [HANDLE_W-1:0] base_ff, base_in;
   logic [HANDLE_W-1:0] walk_ff, walk_in;
   logic [SLOT_W-1:0]   cnt_ff, cnt_in;
   logic                func_ff, func_in;
   logic [HANDLE_W-1:0] hnd_ff, hnd_in;
   logic                pres_ff, pres_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_granted_ff, rsp_granted_in;
   logic [HANDLE_W-1:0] rsp_handle_ff, rsp_handle_in;
   logic [PAGES_W-1:0]  rsp_pages_ff, rsp_pages_in;

   logic                ram_we;
   logic [HANDLE_W-1:0] ram_waddr;
   logic [LINK_W-1:0]   ram_wdata;
   logic [LINK_W-1:0]   ram_rdata;

   logic out_free;
   logic can_prov;

   pfla_ram #(
      .WIDTH (LINK_W),
      .DEPTH (LINK_DEPTH)
   ) u_link_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (head_ff.handle),
      .rdata (ram_rdata)
   );

   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign can_prov = (pages_ff < limit_ff) && (32'(pages_ff) < MAX_PAGES);

   // tail after page provisioning, before the grant check
   assign tail_prov = tail_ff.valid ? tail_ff : link_type'{valid: 1'b1, handle: walk_ff};

   always_comb begin
      state_in       = state_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      pages_in       = pages_ff;
      base_in        = base_ff;
      walk_in        = walk_ff;
      cnt_in         = cnt_ff;
      func_in        = func_ff;
      hnd_in         = hnd_ff;
      pres_in        = pres_ff;
      limit_in       = csr_we ? csr_wdata : limit_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_granted_in = rsp_granted_ff;
      rsp_handle_in  = rsp_handle_ff;
      rsp_pages_in   = rsp_pages_ff;
      ram_we         = 1'b0;
      ram_waddr      = hnd_ff;
      ram_wdata      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               func_in = req_ch.func;
               hnd_in  = req_ch.handle;
               pres_in = req_ch.handle_present;
               if (req_ch.func == FUNC_RETURN) begin
                  // clear the returned entry's link now, tail link in ST_RET
                  ram_we    = req_ch.handle_present;
                  ram_waddr = req_ch.handle;
                  ram_wdata = '0;
                  state_in  = ST_RET;
               end else begin
                  state_in = ST_READ;
               end
            end
         end

         ST_READ: begin
            if (head_ff.valid) begin
               if (out_free) begin
                  head_in        = link_type'(ram_rdata);
                  if (tail_ff.valid && tail_ff.handle == head_ff.handle) begin
                     tail_in = '0;
                  end
                  rsp_valid_in   = 1'b1;
                  rsp_granted_in = 1'b1;
                  rsp_handle_in  = head_ff.handle;
                  rsp_pages_in   = pages_ff;
                  state_in       = ST_IDLE;
               end
            end else if (can_prov) begin
               walk_in  = base_ff;
               cnt_in   = '0;
               state_in = ST_PROV;
            end else if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_granted_in = 1'b0;
               rsp_handle_in  = '0;
               rsp_pages_in   = pages_ff;
               state_in       = ST_IDLE;
            end
         end

         ST_RET: begin
            if (out_free) begin
               if (pres_ff) begin
                  ram_we    = tail_ff.valid;
                  ram_waddr = tail_ff.handle;
                  ram_wdata = {1'b1, hnd_ff};
                  tail_in   = link_type'{valid: 1'b1, handle: hnd_ff};
                  if (!head_ff.valid) begin
                     head_in = link_type'{valid: 1'b1, handle: hnd_ff};
                  end
               end
               rsp_valid_in   = 1'b1;
               rsp_granted_in = 1'b0;
               rsp_handle_in  = '0;
               rsp_pages_in   = pages_ff;
               state_in       = ST_IDLE;
            end
         end

         ST_PROV: begin
            // link slots in order; the last slot takes the old head
            ram_we    = 1'b1;
            ram_waddr = walk_ff;
            ram_wdata = (cnt_ff != SLOT_LAST) ? {1'b1, walk_ff + 1'b1} : head_ff;
            if (cnt_ff == SLOT_LAST) begin
               state_in = ST_PEND;
            end else begin
               walk_in = walk_ff + 1'b1;
               cnt_in  = cnt_ff + 1'b1;
            end
         end

         ST_PEND: begin
            if (out_free) begin
               // walk_ff holds the page's last slot here
               if (PAGE_SLOTS > 1) begin
                  head_in = link_type'{valid: 1'b1, handle: base_ff + 1'b1};
               end else begin
                  head_in = head_ff;
               end
               if (tail_prov.valid && tail_prov.handle == base_ff) begin
                  tail_in = '0;
               end else begin
                  tail_in = tail_prov;
               end
               pages_in       = pages_ff + 1'b1;
               base_in        = base_ff + PAGE_STEP;
               rsp_valid_in   = 1'b1;
               rsp_granted_in = 1'b1;
               rsp_handle_in  = base_ff;
               rsp_pages_in   = pages_ff + 1'b1;
               state_in       = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         pages_ff     <= '0;
         base_ff      <= '0;
         limit_ff     <= PAGE_LIMIT_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         pages_ff     <= pages_in;
         base_ff      <= base_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      walk_ff        <= walk_in;
      cnt_ff         <= cnt_in;
      func_ff        <= func_in;
      hnd_ff         <= hnd_in;
      pres_ff        <= pres_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_handle_ff  <= rsp_handle_in;
      rsp_pages_ff   <= rsp_pages_in;
   end

   assign req_ch.ready          = (state_ff == ST_IDLE);
   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.granted        = rsp_granted_ff;
   assign rsp_ch.granted_handle = rsp_handle_ff;
   assign rsp_ch.pages_used     = rsp_pages_ff;

   `ASSERT_CLK(a_pages_bound, clock, reset, 32'(pages_ff) <= MAX_PAGES,
      "more pages provisioned than the pool allows")
   `ASSERT_CLK(a_prov_writes, clock, reset, (state_ff == ST_PROV) |-> ram_we,
      "page walk cycle without a link write")
   `ASSERT_CLK(a_rsp_source, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff != ST_IDLE),
      "response word appeared without a request in flight")
   `ASSERT_CLK(a_ret_links, clock, reset,
      (state_ff == ST_RET && out_free && pres_ff) |=> (tail_ff.valid && head_ff.valid),
      "return left the free list without a head or tail")

endmodule
